### rtl/core/ndefrp_pkg.sv
// shared byte kinds, error codes, header flag bits and tnf value of the ndef record parser
package ndefrp_pkg;

    localparam logic [2:0] KIND_FLAGS    = 3'd0;
    localparam logic [2:0] KIND_TYPE_LEN = 3'd1;
    localparam logic [2:0] KIND_PAY_LEN  = 3'd2;
    localparam logic [2:0] KIND_ID_LEN   = 3'd3;
    localparam logic [2:0] KIND_TYPE     = 3'd4;
    localparam logic [2:0] KIND_ID       = 3'd5;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd6;
    localparam logic [2:0] KIND_IGNORED  = 3'd7;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_REPEAT_BEGIN = 3'd1;
    localparam logic [2:0] ERR_REPEAT_END   = 3'd2;
    localparam logic [2:0] ERR_CHUNK_RULE   = 3'd3;
    localparam logic [2:0] ERR_CHUNK_TYPE   = 3'd4;
    localparam logic [2:0] ERR_CHUNK_ID     = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED    = 3'd6;

    localparam int FLAG_MB = 7;
    localparam int FLAG_ME = 6;
    localparam int FLAG_CF = 5;
    localparam int FLAG_SR = 4;
    localparam int FLAG_IL = 3;

    localparam logic [2:0] TNF_UNCHANGED = 3'd6;

endpackage

### rtl/core/ndef_record_parser_unit.sv
// NDEF record stream parser: one message byte in, one tagged byte out
// input channel: i_valid / o_stall carry i_data_byte and i_last_byte, one byte a beat;
//   i_last_byte marks the final byte of a message
// output channel: o_valid / i_stall carry the tagged byte: kind, tnf, chunk flag,
//   record end, error code and message end
// an accepted beat goes into the input register, is decoded against the record state
//   and lands in the result register; an output stall can hold it in the input register
// throughput: one byte per cycle while the output is not stalled; the record state is
//   updated by a single pass of logic per byte, so the next byte may follow directly
// a stall on the output holds the result register; the input register still takes
//   one more beat, then o_stall rises until the result register frees
// reset (synchronous, active low) empties both registers and returns the parser to
//   the start of a message; the last header flags are kept across messages
// after an error every further byte of the message comes out as ignored; the final
//   byte of a message always restarts the parser
module ndef_record_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_byte_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_name_format,
    output logic       o_chunk_follows,
    output logic       o_record_done,
    output logic [2:0] o_error_code,
    output logic       o_message_done
);

    typedef enum logic [2:0] {
        PH_FLAGS = 3'd0,
        PH_TLEN  = 3'd1,
        PH_PLEN  = 3'd2,
        PH_ILEN  = 3'd3,
        PH_TYPE  = 3'd4,
        PH_ID    = 3'd5,
        PH_PAY   = 3'd6
    } t_phase;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // record state
    t_phase      r_phase,        n_phase;
    logic [7:0]  r_hdr,          n_hdr;
    logic [1:0]  r_len_left,     n_len_left;
    logic [7:0]  r_type_left,    n_type_left;
    logic [7:0]  r_id_left,      n_id_left;
    logic [31:0] r_pay_left,     n_pay_left;
    logic        r_seen_begin,   n_seen_begin;
    logic        r_seen_end,     n_seen_end;
    logic        r_chunk_pend,   n_chunk_pend;
    logic        r_err_hold,     n_err_hold;

    // result register
    logic       r_out_valid;
    logic [2:0] r_kind;
    logic [7:0] r_byte;
    logic [2:0] r_tnf;
    logic       r_cf;
    logic       r_rec_done;
    logic [2:0] r_err;
    logic       r_msg_done;

    logic       take_in;
    logic       move;
    logic [2:0] kind;
    logic [2:0] err;
    logic       ended;
    logic       rec_done;
    t_phase     adv_phase;

    // next body section after the counters settle; flags phase means record end
    function automatic t_phase body_phase(input logic [7:0]  type_left,
                                          input logic [7:0]  id_left,
                                          input logic [31:0] pay_left);
        t_phase ph;
        if (type_left != 8'd0) begin
            ph = PH_TYPE;
        end else if (id_left != 8'd0) begin
            ph = PH_ID;
        end else if (pay_left != 32'd0) begin
            ph = PH_PAY;
        end else begin
            ph = PH_FLAGS;
        end
        return ph;
    endfunction

    assign move    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !move;
    assign take_in = i_valid && !o_stall;

    always_comb begin
        n_phase      = r_phase;
        n_hdr        = r_hdr;
        n_len_left   = r_len_left;
        n_type_left  = r_type_left;
        n_id_left    = r_id_left;
        n_pay_left   = r_pay_left;
        n_seen_begin = r_seen_begin;
        n_seen_end   = r_seen_end;
        n_chunk_pend = r_chunk_pend;
        n_err_hold   = r_err_hold;
        kind         = ndefrp_pkg::KIND_IGNORED;
        err          = ndefrp_pkg::ERR_NONE;
        ended        = 1'b0;
        adv_phase    = PH_FLAGS;

        if (!r_err_hold) begin
            case (r_phase)
                PH_TLEN: begin
                    kind        = ndefrp_pkg::KIND_TYPE_LEN;
                    n_type_left = r_in_byte;
                    if (r_hdr[2:0] == ndefrp_pkg::TNF_UNCHANGED && r_in_byte != 8'd0) begin
                        err = ndefrp_pkg::ERR_CHUNK_TYPE;
                    end else begin
                        n_phase    = PH_PLEN;
                        n_len_left = r_hdr[ndefrp_pkg::FLAG_SR] ? 2'd0 : 2'd3;
                    end
                end
                PH_PLEN: begin
                    kind       = ndefrp_pkg::KIND_PAY_LEN;
                    n_pay_left = {r_pay_left[23:0], r_in_byte};
                    if (r_len_left == 2'd0) begin
                        if (r_hdr[ndefrp_pkg::FLAG_IL]) begin
                            n_phase = PH_ILEN;
                        end else begin
                            adv_phase = body_phase(r_type_left, r_id_left, n_pay_left);
                            n_phase   = adv_phase;
                            ended     = (adv_phase == PH_FLAGS);
                        end
                    end else begin
                        n_len_left = r_len_left - 2'd1;
                    end
                end
                PH_ILEN: begin
                    kind      = ndefrp_pkg::KIND_ID_LEN;
                    n_id_left = r_in_byte;
                    if (r_hdr[2:0] == ndefrp_pkg::TNF_UNCHANGED && r_in_byte != 8'd0) begin
                        err = ndefrp_pkg::ERR_CHUNK_ID;
                    end else begin
                        adv_phase = body_phase(r_type_left, r_in_byte, r_pay_left);
                        n_phase   = adv_phase;
                        ended     = (adv_phase == PH_FLAGS);
                    end
                end
                PH_TYPE: begin
                    kind = ndefrp_pkg::KIND_TYPE;
                    if (r_type_left != 8'd0) begin
                        n_type_left = r_type_left - 8'd1;
                    end
                    adv_phase = body_phase(n_type_left, r_id_left, r_pay_left);
                    n_phase   = adv_phase;
                    ended     = (adv_phase == PH_FLAGS);
                end
                PH_ID: begin
                    kind = ndefrp_pkg::KIND_ID;
                    if (r_id_left != 8'd0) begin
                        n_id_left = r_id_left - 8'd1;
                    end
                    adv_phase = body_phase(r_type_left, n_id_left, r_pay_left);
                    n_phase   = adv_phase;
                    ended     = (adv_phase == PH_FLAGS);
                end
                PH_PAY: begin
                    kind = ndefrp_pkg::KIND_PAYLOAD;
                    if (r_pay_left != 32'd0) begin
                        n_pay_left = r_pay_left - 32'd1;
                    end
                    adv_phase = body_phase(r_type_left, r_id_left, n_pay_left);
                    n_phase   = adv_phase;
                    ended     = (adv_phase == PH_FLAGS);
                end
                default: begin
                    kind  = ndefrp_pkg::KIND_FLAGS;
                    n_hdr = r_in_byte;
                    if (r_in_byte[ndefrp_pkg::FLAG_MB] && r_seen_begin) begin
                        err = ndefrp_pkg::ERR_REPEAT_BEGIN;
                    end else if (r_in_byte[ndefrp_pkg::FLAG_ME] && r_seen_end) begin
                        err = ndefrp_pkg::ERR_REPEAT_END;
                    end else if (r_chunk_pend !=
                                 (r_in_byte[2:0] == ndefrp_pkg::TNF_UNCHANGED)) begin
                        err = ndefrp_pkg::ERR_CHUNK_RULE;
                    end else begin
                        n_seen_begin = 1'b1;
                        if (r_in_byte[ndefrp_pkg::FLAG_ME]) begin
                            n_seen_end = 1'b1;
                        end
                        n_chunk_pend = r_in_byte[ndefrp_pkg::FLAG_CF];
                        n_type_left  = 8'd0;
                        n_id_left    = 8'd0;
                        n_pay_left   = 32'd0;
                        n_len_left   = 2'd0;
                        n_phase      = PH_TLEN;
                    end
                end
            endcase

            if (err != ndefrp_pkg::ERR_NONE) begin
                n_err_hold = 1'b1;
                ended      = 1'b0;
            end else if (r_in_last && (n_phase != PH_FLAGS || n_chunk_pend)) begin
                err        = ndefrp_pkg::ERR_TRUNCATED;
                n_err_hold = 1'b1;
            end
        end

        // end of message restarts the parser, header flags stay
        if (r_in_last) begin
            n_phase      = PH_FLAGS;
            n_len_left   = 2'd0;
            n_type_left  = 8'd0;
            n_id_left    = 8'd0;
            n_pay_left   = 32'd0;
            n_seen_begin = 1'b0;
            n_seen_end   = 1'b0;
            n_chunk_pend = 1'b0;
            n_err_hold   = 1'b0;
        end
    end

    assign rec_done = ended && (err == ndefrp_pkg::ERR_NONE) && !n_hdr[ndefrp_pkg::FLAG_CF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_FLAGS;
            r_hdr        <= 8'd0;
            r_len_left   <= 2'd0;
            r_type_left  <= 8'd0;
            r_id_left    <= 8'd0;
            r_pay_left   <= 32'd0;
            r_seen_begin <= 1'b0;
            r_seen_end   <= 1'b0;
            r_chunk_pend <= 1'b0;
            r_err_hold   <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end

            if (move) begin
                r_out_valid  <= 1'b1;
                r_phase      <= n_phase;
                r_hdr        <= n_hdr;
                r_len_left   <= n_len_left;
                r_type_left  <= n_type_left;
                r_id_left    <= n_id_left;
                r_pay_left   <= n_pay_left;
                r_seen_begin <= n_seen_begin;
                r_seen_end   <= n_seen_end;
                r_chunk_pend <= n_chunk_pend;
                r_err_hold   <= n_err_hold;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (take_in) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end

        if (move) begin
            r_kind     <= kind;
            r_byte     <= r_in_byte;
            r_err      <= err;
            r_msg_done <= r_in_last;
            if (kind == ndefrp_pkg::KIND_IGNORED) begin
                r_tnf      <= 3'd0;
                r_cf       <= 1'b0;
                r_rec_done <= 1'b0;
            end else begin
                r_tnf      <= n_hdr[2:0];
                r_cf       <= n_hdr[ndefrp_pkg::FLAG_CF];
                r_rec_done <= rec_done;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_byte_kind     = r_kind;
    assign o_out_byte      = r_byte;
    assign o_name_format   = r_tnf;
    assign o_chunk_follows = r_cf;
    assign o_record_done   = r_rec_done;
    assign o_error_code    = r_err;
    assign o_message_done  = r_msg_done;

endmodule

### rtl/core/ndefrp_checker.sv
// port-level checks of the ndef record parser, bound to the top level
module ndefrp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_byte_kind,
    input logic [7:0] o_out_byte,
    input logic [2:0] o_name_format,
    input logic       o_chunk_follows,
    input logic       o_record_done,
    input logic [2:0] o_error_code,
    input logic       o_message_done
);

    // a held beat keeps its kind, byte, error code and message end
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_byte_kind) && $stable(o_out_byte)
            && $stable(o_error_code) && $stable(o_message_done))
        else $error("stalled result changed");

    // a record end is clean, never on a flags byte and never a chunk
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_done |-> o_error_code == ndefrp_pkg::ERR_NONE
            && o_byte_kind != ndefrp_pkg::KIND_IGNORED
            && o_byte_kind != ndefrp_pkg::KIND_FLAGS && !o_chunk_follows)
        else $error("record end on a bad beat");

    // ignored bytes carry no header information and no error
    a_ignored_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_kind == ndefrp_pkg::KIND_IGNORED |-> o_name_format == 3'd0
            && !o_chunk_follows && !o_record_done
            && o_error_code == ndefrp_pkg::ERR_NONE)
        else $error("ignored byte carries fields");

    // truncation is only seen on the final byte
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code == ndefrp_pkg::ERR_TRUNCATED |-> o_message_done)
        else $error("truncation before message end");

endmodule

bind ndef_record_parser_unit ndefrp_checker u_ndefrp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_byte_kind     (o_byte_kind),
    .o_out_byte      (o_out_byte),
    .o_name_format   (o_name_format),
    .o_chunk_follows (o_chunk_follows),
    .o_record_done   (o_record_done),
    .o_error_code    (o_error_code),
    .o_message_done  (o_message_done)
);

### test/ndef_record_parser_checker.sv
// channel monitor, byte predictor and result comparison for the ndef record parser
`timescale 1ns / 1ps

module ndef_record_parser_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_byte_kind,
    input  logic [7:0] i_out_byte,
    input  logic [2:0] i_name_format,
    input  logic       i_chunk_follows,
    input  logic       i_record_done,
    input  logic [2:0] i_error_code,
    input  logic       i_message_done,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] tnf;
        logic       chunk;
        logic       rec_end;
        logic [2:0] err;
        logic       msg_end;
    } t_parsed_byte;

    // numbered like the byte kinds, so a state doubles as the kind of its byte
    typedef enum logic [2:0] {
        ST_FLAGS, ST_TYPE_LEN, ST_PAY_LEN, ST_ID_LEN, ST_TYPE, ST_ID, ST_PAYLOAD
    } t_parse_state;

    t_parse_state cur_phase;
    logic [7:0]   hdr;
    logic [1:0]   len_left;
    logic [7:0]   type_left;
    logic [7:0]   id_left;
    logic [31:0]  payload_left;
    logic         begin_seen;
    logic         end_seen;
    logic         chunk_open;
    logic         discard_rest;

    t_parsed_byte expected_bytes[$];
    int           fail_count = 0;
    int           out_beats = 0;

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("output beat %0d: %s", out_beats, what);
        end
    endtask

    task automatic restart_message();
        cur_phase = ST_FLAGS;
        len_left = '0;
        type_left = '0;
        id_left = '0;
        payload_left = '0;
        begin_seen = 1'b0;
        end_seen = 1'b0;
        chunk_open = 1'b0;
        discard_rest = 1'b0;
    endtask

    // step into the next non-empty body section; 1 when the record is over
    function automatic logic next_section();
        if (type_left != 0) begin
            cur_phase = ST_TYPE;
            return 1'b0;
        end
        if (id_left != 0) begin
            cur_phase = ST_ID;
            return 1'b0;
        end
        if (payload_left != 0) begin
            cur_phase = ST_PAYLOAD;
            return 1'b0;
        end
        cur_phase = ST_FLAGS;
        return 1'b1;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic last, output t_parsed_byte r);
        logic       ended;
        logic [2:0] kind;
        logic [2:0] err;
        logic [2:0] tnf;
        ended = 1'b0;
        err = ndefrp_pkg::ERR_NONE;
        if (discard_rest) begin
            kind = ndefrp_pkg::KIND_IGNORED;
        end else begin
            kind = cur_phase;
            case (cur_phase)
                ST_TYPE_LEN: begin
                    type_left = b;
                    if (hdr[2:0] == ndefrp_pkg::TNF_UNCHANGED && b != 0) begin
                        err = ndefrp_pkg::ERR_CHUNK_TYPE;
                    end else begin
                        cur_phase = ST_PAY_LEN;
                        len_left = hdr[ndefrp_pkg::FLAG_SR] ? 2'd0 : 2'd3;
                    end
                end
                ST_PAY_LEN: begin
                    // length bytes arrive big-endian
                    payload_left = {payload_left[23:0], b};
                    if (len_left == 0) begin
                        if (hdr[ndefrp_pkg::FLAG_IL]) cur_phase = ST_ID_LEN;
                        else ended = next_section();
                    end else begin
                        len_left = len_left - 2'd1;
                    end
                end
                ST_ID_LEN: begin
                    id_left = b;
                    if (hdr[2:0] == ndefrp_pkg::TNF_UNCHANGED && b != 0)
                        err = ndefrp_pkg::ERR_CHUNK_ID;
                    else ended = next_section();
                end
                ST_TYPE: begin
                    if (type_left != 0) type_left--;
                    ended = next_section();
                end
                ST_ID: begin
                    if (id_left != 0) id_left--;
                    ended = next_section();
                end
                ST_PAYLOAD: begin
                    if (payload_left != 0) payload_left--;
                    ended = next_section();
                end
                default: begin
                    kind = ndefrp_pkg::KIND_FLAGS;
                    hdr = b;
                    tnf = b[2:0];
                    if (b[ndefrp_pkg::FLAG_MB] && begin_seen) begin
                        err = ndefrp_pkg::ERR_REPEAT_BEGIN;
                    end else if (b[ndefrp_pkg::FLAG_ME] && end_seen) begin
                        err = ndefrp_pkg::ERR_REPEAT_END;
                    end else if (chunk_open != (tnf == ndefrp_pkg::TNF_UNCHANGED)) begin
                        // continuation chunks must say unchanged, nothing else may
                        err = ndefrp_pkg::ERR_CHUNK_RULE;
                    end else begin
                        begin_seen = 1'b1;
                        if (b[ndefrp_pkg::FLAG_ME]) end_seen = 1'b1;
                        chunk_open = b[ndefrp_pkg::FLAG_CF];
                        type_left = '0;
                        id_left = '0;
                        payload_left = '0;
                        len_left = '0;
                        cur_phase = ST_TYPE_LEN;
                    end
                end
            endcase
            if (err != ndefrp_pkg::ERR_NONE) begin
                discard_rest = 1'b1;
                ended = 1'b0;
            end else if (last && (cur_phase != ST_FLAGS || chunk_open)) begin
                err = ndefrp_pkg::ERR_TRUNCATED;
                discard_rest = 1'b1;
            end
        end

        r.kind = kind;
        r.data = b;
        r.err = err;
        r.msg_end = last;
        if (kind == ndefrp_pkg::KIND_IGNORED) begin
            r.tnf = '0;
            r.chunk = 1'b0;
            r.rec_end = 1'b0;
        end else begin
            r.tnf = hdr[2:0];
            r.chunk = hdr[ndefrp_pkg::FLAG_CF];
            r.rec_end = ended && err == ndefrp_pkg::ERR_NONE && !hdr[ndefrp_pkg::FLAG_CF];
        end
        if (last) restart_message();
    endtask

    always @(posedge i_clk) begin : watch
        t_parsed_byte want;
        t_parsed_byte got;
        if (!i_rst_n) begin
            restart_message();
            hdr = '0;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_byte_kind, i_out_byte, i_name_format, i_chunk_follows,
                       i_record_done, i_error_code, i_message_done};
                if (expected_bytes.size() == 0) begin
                    report_failure("result beat with no byte outstanding");
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.kind !== want.kind)
                        report_failure($sformatf("byte_kind %0d, expected %0d",
                                                 got.kind, want.kind));
                    if (got.data !== want.data)
                        report_failure($sformatf("out_byte %0d, expected %0d",
                                                 got.data, want.data));
                    if (got.tnf !== want.tnf)
                        report_failure($sformatf("name_format %0d, expected %0d",
                                                 got.tnf, want.tnf));
                    if (got.chunk !== want.chunk)
                        report_failure($sformatf("chunk_follows %0d, expected %0d",
                                                 got.chunk, want.chunk));
                    if (got.rec_end !== want.rec_end)
                        report_failure($sformatf("record_done %0d, expected %0d",
                                                 got.rec_end, want.rec_end));
                    if (got.err !== want.err)
                        report_failure($sformatf("error_code %0d, expected %0d",
                                                 got.err, want.err));
                    if (got.msg_end !== want.msg_end)
                        report_failure($sformatf("message_done %0d, expected %0d",
                                                 got.msg_end, want.msg_end));
                end
                out_beats++;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_byte(i_data_byte, i_last_byte, want);
                expected_bytes.push_back(want);
            end
        end
        o_fail_count <= fail_count;
        o_pending <= expected_bytes.size();
    end

endmodule

### test/testbench.sv
// stimulus, pacing, watchdog and verdict for the ndef record parser
`timescale 1ns / 1ps

module testbench;

    localparam int         RANDOM_ITEMS    = 1550;
    localparam int         DIRECTED_N      = 27;
    localparam int         TX_SLOW_FROM    = 550;
    localparam int         FULL_RATE_FROM  = 1070;
    localparam int         HOLD_OFF_AT     = FULL_RATE_FROM + 40;
    localparam int         HOLD_OFF_CYCLES = 60;
    localparam int         WATCHDOG_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam logic [2:0] TNF_RESERVED    = 3'd7;

    typedef enum logic [1:0] {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} t_pace;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_data_byte = '0;
    logic       i_last_byte = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_byte_kind;
    logic [7:0] o_out_byte;
    logic [2:0] o_name_format;
    logic       o_chunk_follows;
    logic       o_record_done;
    logic [2:0] o_error_code;
    logic       o_message_done;

    int         fail_count;
    int         pending;
    int         sent_count = 0;
    int         quiet_cycles = 0;
    t_pace      pace = PACE_RX_SLOW;
    logic       wild_hdrs = 1'b0;
    logic [7:0] msg_bytes[$];

    // bit 8 marks the last byte of a message
    logic [8:0] directed_beats [0:DIRECTED_N-1] = '{
        // one complete record touching every byte kind but ignored, ends on 0xff
        9'h0D9, 9'h001, 9'h001, 9'h001, 9'h055, 9'h0AA, 9'h1FF,
        // second message begin, then an ignored byte
        9'h091, 9'h000, 9'h000, 9'h091, 9'h100,
        // second message end
        9'h051, 9'h000, 9'h000, 9'h151,
        // unchanged tnf with no chunk open
        9'h116,
        // continuation chunk with a type length, error beats truncation
        9'h031, 9'h000, 9'h000, 9'h016, 9'h101,
        // tnf 7, cut short on a full type length
        9'h007, 9'h1FF,
        // record without me closing the message cleanly
        9'h011, 9'h000, 9'h100
    };

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    ndef_record_parser_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_kind    (o_byte_kind),
        .o_out_byte     (o_out_byte),
        .o_name_format  (o_name_format),
        .o_chunk_follows(o_chunk_follows),
        .o_record_done  (o_record_done),
        .o_error_code   (o_error_code),
        .o_message_done (o_message_done)
    );

    ndef_record_parser_checker check_u (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_byte_kind    (o_byte_kind),
        .i_out_byte     (o_out_byte),
        .i_name_format  (o_name_format),
        .i_chunk_follows(o_chunk_follows),
        .i_record_done  (o_record_done),
        .i_error_code   (o_error_code),
        .i_message_done (o_message_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // offers one beat from a falling edge and returns at the falling edge after it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        pace = (sent_count < TX_SLOW_FROM) ? PACE_RX_SLOW :
               (sent_count < FULL_RATE_FROM) ? PACE_TX_SLOW : PACE_FULL;
        while ($urandom_range(99) < (pace == PACE_RX_SLOW ? 27 :
                                     pace == PACE_TX_SLOW ? 67 : 0)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic add_record(input logic mb, input logic me, input logic cf,
                              input logic [2:0] tnf, input logic cont);
        logic        sr;
        logic        il;
        logic [7:0]  tlen;
        logic [7:0]  ilen;
        logic [31:0] plen;
        sr = ($urandom_range(99) < 70);
        il = 1'($urandom_range(1));
        tlen = 8'($urandom_range(4));
        if ($urandom_range(49) == 0) tlen = 8'($urandom_range(255));
        ilen = il ? 8'($urandom_range(3)) : 8'd0;
        // continuation chunks carry no type or id unless the headers are broken on purpose
        if (cont && !wild_hdrs) begin
            tlen = '0;
            ilen = '0;
        end
        plen = $urandom_range(10);
        if ($urandom_range(24) == 0) plen = sr ? $urandom_range(255) : $urandom_range(256, 700);
        msg_bytes.push_back({mb, me, cf, sr, il, tnf});
        msg_bytes.push_back(tlen);
        if (sr) msg_bytes.push_back(plen[7:0]);
        else for (int s = 24; s >= 0; s -= 8) msg_bytes.push_back(plen[s +: 8]);
        if (il) msg_bytes.push_back(ilen);
        repeat (int'(tlen) + int'(ilen) + int'(plen)) msg_bytes.push_back(8'($urandom));
    endtask

    initial begin : stimulus
        logic [2:0] rec_tnf[$];
        logic       rec_cf[$];
        logic       rec_cont[$];
        logic [2:0] free_tnf;
        logic       messy;
        int         n_chunks;
        int         keep;
        int         pick;
        int         last_rec;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_beats[k]) send_byte(directed_beats[k][7:0], directed_beats[k][8]);

        while (sent_count < DIRECTED_N + RANDOM_ITEMS) begin
            messy = ($urandom_range(99) < 20);
            wild_hdrs = messy && ($urandom_range(2) == 0);
            rec_tnf.delete();
            rec_cf.delete();
            rec_cont.delete();
            msg_bytes.delete();
            // plain records and chunk runs, in random order
            repeat ($urandom_range(1, 3)) begin
                pick = int'($urandom_range(6));
                free_tnf = (pick == ndefrp_pkg::TNF_UNCHANGED) ? TNF_RESERVED : 3'(pick);
                n_chunks = ($urandom_range(3) == 0) ? int'($urandom_range(2, 4)) : 1;
                for (int c = 0; c < n_chunks; c++) begin
                    rec_tnf.push_back(c == 0 ? free_tnf : ndefrp_pkg::TNF_UNCHANGED);
                    rec_cf.push_back(c != n_chunks - 1);
                    rec_cont.push_back(c != 0);
                end
            end
            last_rec = rec_tnf.size() - 1;
            foreach (rec_tnf[r]) begin
                if (wild_hdrs)
                    add_record(1'($urandom_range(1)), 1'($urandom_range(1)), rec_cf[r],
                               rec_tnf[r], rec_cont[r]);
                else
                    add_record(r == 0, r == last_rec && $urandom_range(9) != 0, rec_cf[r],
                               rec_tnf[r], rec_cont[r]);
            end
            if (messy && !wild_hdrs) begin
                case ($urandom_range(2))
                    0: begin
                        keep = int'($urandom_range(1, msg_bytes.size()));
                        while (msg_bytes.size() > keep) msg_bytes.delete(msg_bytes.size() - 1);
                    end
                    1: msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom);
                    default: begin
                        msg_bytes.delete();
                        repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
                    end
                endcase
            end
            foreach (msg_bytes[k]) send_byte(msg_bytes[k], k == msg_bytes.size() - 1);
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : receiver
        logic held_off;
        held_off = 1'b0;
        forever begin
            @(negedge i_clk);
            // one long hold-off while the sender runs flat out, so the parser backs up
            if (!held_off && sent_count >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            i_stall <= ($urandom_range(99) < (pace == PACE_RX_SLOW ? 67 :
                                              pace == PACE_TX_SLOW ? 27 : 0));
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
